// ===== hw/rtl/spcd_pkg.sv =====
package spcd_pkg;

  // Field and datapath widths
  localparam int CW        = 24;          // coordinate, signed Q16.8
  localparam int PW        = CW + 1;      // start difference
  localparam int PRW       = 50;          // dot product term
  localparam int DOTW      = 51;          // dot product
  localparam int MW        = 52;          // wide multiplier operand
  localparam int WW        = 2 * MW;      // wide product
  localparam int MPW       = 42;          // coordinate times parameter
  localparam int FW        = 17;          // Q1.16 parameter
  localparam int DW        = 54;          // squared distance
  localparam int LW        = 32;          // near-zero limit
  localparam int FRAC_BITS = 16;
  localparam int DIV_STEPS = FRAC_BITS;
  localparam int DIST_SHIFT = 32;
  localparam int SAT_BIT   = DW + DIST_SHIFT;
  localparam int IN_W      = 12 * CW;
  localparam int OUT_W     = DW + 2 * FW;
  localparam int QDEPTH    = 4;
  localparam int QAW       = 2;

  localparam logic [FW-1:0] ONE_Q16     = FW'(1) << FRAC_BITS;
  localparam logic [LW-1:0] LIMIT_RESET = LW'(1);

  typedef logic signed [CW-1:0]   coord_t;
  typedef logic signed [PW-1:0]   diff_t;
  typedef logic signed [PRW-1:0]  prod_t;
  typedef logic signed [DOTW-1:0] dot_t;
  typedef logic signed [MW-1:0]   mop_t;
  typedef logic signed [WW-1:0]   wide_t;
  typedef logic signed [MPW-1:0]  mp_t;
  typedef logic [FW-1:0]          frac_t;
  typedef logic [DW-1:0]          dist_t;

  typedef struct packed {
    coord_t [2:0] u;
    coord_t [2:0] v;
    diff_t  [2:0] w;
  } geom_t;

  typedef struct packed {
    dot_t a;
    dot_t b;
    dot_t c;
    dot_t d;
    dot_t e;
  } dots_t;

  // One classified pair, handed from front to back
  typedef struct packed {
    wide_t sn;
    wide_t sd;
    wide_t tn;
    wide_t td;
    logic  s_one;
    geom_t g;
  } job_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

endpackage

// ===== hw/rtl/spcd_wmul.sv =====
// Signed 52x52 multiply, split into four partial products.
module spcd_wmul (
  input  logic           clk,
  input  logic           en,
  input  spcd_pkg::mop_t x,
  input  spcd_pkg::mop_t y,
  output spcd_pkg::wide_t p
);

  localparam int HW = spcd_pkg::MW / 2;

  logic [HW-1:0]          xl, yl;
  logic signed [HW-1:0]   xh, yh;
  logic [2*HW-1:0]        ll_r;
  logic signed [2*HW:0]   lh_r, hl_r;
  logic signed [2*HW-1:0] hh_r;
  spcd_pkg::wide_t        p_r;

  assign xl = x[HW-1:0];
  assign yl = y[HW-1:0];
  assign xh = x[2*HW-1:HW];
  assign yh = y[2*HW-1:HW];

  // partial products
  always_ff @(posedge clk) begin
    if (en) begin
      ll_r <= (2*HW)'(xl) * (2*HW)'(yl);
      lh_r <= (2*HW+1)'($signed({1'b0, xl})) * (2*HW+1)'(yh);
      hl_r <= (2*HW+1)'(xh) * (2*HW+1)'($signed({1'b0, yl}));
      hh_r <= (2*HW)'(xh) * (2*HW)'(yh);
    end
  end

  // recombine
  always_ff @(posedge clk) begin
    if (en) begin
      p_r <= (spcd_pkg::wide_t'(hh_r) <<< (2 * HW))
           + ((spcd_pkg::wide_t'(lh_r) + spcd_pkg::wide_t'(hl_r)) <<< HW)
           + spcd_pkg::wide_t'({1'b0, ll_r});
    end
  end

  assign p = p_r;

endmodule

// ===== hw/rtl/spcd_front.sv =====
// Front: dot products, determinant, numerators, clamp classification.
module spcd_front (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       en,
  input  logic                       in_valid,
  input  logic [spcd_pkg::IN_W-1:0]  in_data,
  input  logic [spcd_pkg::LW-1:0]    lim,
  output logic                       out_valid,
  output spcd_pkg::job_t             out_job
);

  typedef struct packed {
    logic par;
    logic sn_le0;
    logic sn_ge;
    logic tw_le0;
    logic tw_ge;
    logic e_le0;
    logic e_ge;
    logic eb_le0;
    logic eb_ge;
    logic n1_le0;
    logic n1_ge;
    logic n2_le0;
    logic n2_ge;
  } flags_t;

  logic [8:1]             v_r;
  spcd_pkg::geom_t        g_r [1:7];
  spcd_pkg::geom_t        g_n;
  spcd_pkg::prod_t        puu_r [3], puv_r [3], pvv_r [3], puw_r [3], pvw_r [3];
  spcd_pkg::prod_t        puu_n [3], puv_n [3], pvv_n [3], puw_n [3], pvw_n [3];
  spcd_pkg::dots_t        d_r [3:7];
  spcd_pkg::dots_t        d_n;
  spcd_pkg::wide_t        ac, bb, be, cd, ae, bd;
  spcd_pkg::wide_t        det6_r, sn6_r, tn6_r;
  spcd_pkg::wide_t        det7_r, sn7_r, tn7_r;
  spcd_pkg::mop_t         eb7_r, nd1_7_r, nd2_7_r;
  spcd_pkg::mop_t         eb_n, nd1_n, nd2_n;
  flags_t                 fl7_r, fl_n;
  spcd_pkg::wide_t        lim_w;
  spcd_pkg::job_t         job8_r, job_n;

  assign lim_w = spcd_pkg::wide_t'({1'b0, lim});

  // unpack, start difference
  always_comb begin
    for (int k = 0; k < 3; k++) begin
      g_n.u[k] = in_data[(3 + k) * spcd_pkg::CW +: spcd_pkg::CW];
      g_n.v[k] = in_data[(9 + k) * spcd_pkg::CW +: spcd_pkg::CW];
      g_n.w[k] = spcd_pkg::diff_t'($signed(in_data[k * spcd_pkg::CW +: spcd_pkg::CW]))
               - spcd_pkg::diff_t'($signed(in_data[(6 + k) * spcd_pkg::CW +: spcd_pkg::CW]));
    end
  end

  // per-component products
  always_comb begin
    spcd_pkg::coord_t uk, vk;
    spcd_pkg::diff_t  wk;
    for (int k = 0; k < 3; k++) begin
      uk = g_r[1].u[k];
      vk = g_r[1].v[k];
      wk = g_r[1].w[k];
      puu_n[k] = spcd_pkg::prod_t'(uk) * spcd_pkg::prod_t'(uk);
      puv_n[k] = spcd_pkg::prod_t'(uk) * spcd_pkg::prod_t'(vk);
      pvv_n[k] = spcd_pkg::prod_t'(vk) * spcd_pkg::prod_t'(vk);
      puw_n[k] = spcd_pkg::prod_t'(uk) * spcd_pkg::prod_t'(wk);
      pvw_n[k] = spcd_pkg::prod_t'(vk) * spcd_pkg::prod_t'(wk);
    end
  end

  // dot products
  always_comb begin
    d_n.a = spcd_pkg::dot_t'(puu_r[0]) + spcd_pkg::dot_t'(puu_r[1]) + spcd_pkg::dot_t'(puu_r[2]);
    d_n.b = spcd_pkg::dot_t'(puv_r[0]) + spcd_pkg::dot_t'(puv_r[1]) + spcd_pkg::dot_t'(puv_r[2]);
    d_n.c = spcd_pkg::dot_t'(pvv_r[0]) + spcd_pkg::dot_t'(pvv_r[1]) + spcd_pkg::dot_t'(pvv_r[2]);
    d_n.d = spcd_pkg::dot_t'(puw_r[0]) + spcd_pkg::dot_t'(puw_r[1]) + spcd_pkg::dot_t'(puw_r[2]);
    d_n.e = spcd_pkg::dot_t'(pvw_r[0]) + spcd_pkg::dot_t'(pvw_r[1]) + spcd_pkg::dot_t'(pvw_r[2]);
  end

  // wide products, registered partial products then registered recombined sum
  spcd_wmul u_mul_ac (.clk, .en, .x(spcd_pkg::mop_t'(d_r[3].a)), .y(spcd_pkg::mop_t'(d_r[3].c)), .p(ac));
  spcd_wmul u_mul_bb (.clk, .en, .x(spcd_pkg::mop_t'(d_r[3].b)), .y(spcd_pkg::mop_t'(d_r[3].b)), .p(bb));
  spcd_wmul u_mul_be (.clk, .en, .x(spcd_pkg::mop_t'(d_r[3].b)), .y(spcd_pkg::mop_t'(d_r[3].e)), .p(be));
  spcd_wmul u_mul_cd (.clk, .en, .x(spcd_pkg::mop_t'(d_r[3].c)), .y(spcd_pkg::mop_t'(d_r[3].d)), .p(cd));
  spcd_wmul u_mul_ae (.clk, .en, .x(spcd_pkg::mop_t'(d_r[3].a)), .y(spcd_pkg::mop_t'(d_r[3].e)), .p(ae));
  spcd_wmul u_mul_bd (.clk, .en, .x(spcd_pkg::mop_t'(d_r[3].b)), .y(spcd_pkg::mop_t'(d_r[3].d)), .p(bd));

  // all compares in parallel
  always_comb begin
    eb_n  = spcd_pkg::mop_t'(d_r[6].e) + spcd_pkg::mop_t'(d_r[6].b);
    nd1_n = -spcd_pkg::mop_t'(d_r[6].d);
    nd2_n = spcd_pkg::mop_t'(d_r[6].b) - spcd_pkg::mop_t'(d_r[6].d);
    fl_n.par    = det6_r < lim_w;
    fl_n.sn_le0 = sn6_r <= 0;
    fl_n.sn_ge  = sn6_r >= det6_r;
    fl_n.tw_le0 = tn6_r <= 0;
    fl_n.tw_ge  = tn6_r >= det6_r;
    fl_n.e_le0  = d_r[6].e <= 0;
    fl_n.e_ge   = d_r[6].e >= d_r[6].c;
    fl_n.eb_le0 = eb_n <= 0;
    fl_n.eb_ge  = eb_n >= spcd_pkg::mop_t'(d_r[6].c);
    fl_n.n1_le0 = nd1_n <= 0;
    fl_n.n1_ge  = nd1_n >= spcd_pkg::mop_t'(d_r[6].a);
    fl_n.n2_le0 = nd2_n <= 0;
    fl_n.n2_ge  = nd2_n >= spcd_pkg::mop_t'(d_r[6].a);
  end

  // select numerators and denominators
  always_comb begin
    logic           t_le0, t_ge, use_nd, nd_le0, nd_ge;
    spcd_pkg::mop_t nd;
    job_n.sn    = sn7_r;
    job_n.sd    = det7_r;
    job_n.tn    = tn7_r;
    job_n.td    = det7_r;
    job_n.s_one = 1'b0;
    job_n.g     = g_r[7];
    t_le0       = fl7_r.tw_le0;
    t_ge        = fl7_r.tw_ge;
    if (fl7_r.par) begin
      job_n.sn = '0;
      job_n.sd = spcd_pkg::wide_t'(1);
      job_n.tn = spcd_pkg::wide_t'(d_r[7].e);
      job_n.td = spcd_pkg::wide_t'(d_r[7].c);
      t_le0    = fl7_r.e_le0;
      t_ge     = fl7_r.e_ge;
    end else if (fl7_r.sn_le0) begin
      job_n.sn = '0;
      job_n.tn = spcd_pkg::wide_t'(d_r[7].e);
      job_n.td = spcd_pkg::wide_t'(d_r[7].c);
      t_le0    = fl7_r.e_le0;
      t_ge     = fl7_r.e_ge;
    end else if (fl7_r.sn_ge) begin
      job_n.sn    = det7_r;
      job_n.s_one = 1'b1;
      job_n.tn    = spcd_pkg::wide_t'(eb7_r);
      job_n.td    = spcd_pkg::wide_t'(d_r[7].c);
      t_le0       = fl7_r.eb_le0;
      t_ge        = fl7_r.eb_ge;
    end
    // t clamped at an edge: recompute s against it
    use_nd = 1'b0;
    nd     = nd1_7_r;
    nd_le0 = fl7_r.n1_le0;
    nd_ge  = fl7_r.n1_ge;
    if (t_le0) begin
      job_n.tn = '0;
      use_nd   = 1'b1;
    end else if (t_ge) begin
      job_n.tn = job_n.td;
      use_nd   = 1'b1;
      nd       = nd2_7_r;
      nd_le0   = fl7_r.n2_le0;
      nd_ge    = fl7_r.n2_ge;
    end
    if (use_nd) begin
      if (nd_le0) begin
        job_n.sn    = '0;
        job_n.s_one = 1'b0;
      end else if (nd_ge) begin
        job_n.s_one = 1'b1;
      end else begin
        job_n.sn    = spcd_pkg::wide_t'(nd);
        job_n.sd    = spcd_pkg::wide_t'(d_r[7].a);
        job_n.s_one = 1'b0;
      end
    end
  end

  // stage valids
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else if (en) begin
      v_r <= {v_r[7:1], in_valid};
    end
  end

  // stage payloads
  always_ff @(posedge clk) begin
    if (en) begin
      g_r[1] <= g_n;
      for (int i = 2; i <= 7; i++) g_r[i] <= g_r[i - 1];
      puu_r <= puu_n;
      puv_r <= puv_n;
      pvv_r <= pvv_n;
      puw_r <= puw_n;
      pvw_r <= pvw_n;
      d_r[3] <= d_n;
      for (int i = 4; i <= 7; i++) d_r[i] <= d_r[i - 1];
      det6_r  <= ac - bb;
      sn6_r   <= be - cd;
      tn6_r   <= ae - bd;
      det7_r  <= det6_r;
      sn7_r   <= sn6_r;
      tn7_r   <= tn6_r;
      eb7_r   <= eb_n;
      nd1_7_r <= nd1_n;
      nd2_7_r <= nd2_n;
      fl7_r   <= fl_n;
      job8_r  <= job_n;
    end
  end

  assign out_valid = v_r[8];
  assign out_job   = job8_r;

endmodule

// ===== hw/rtl/spcd_queue.sv =====
// Short queue between front and back.
module spcd_queue (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               push,
  input  spcd_pkg::job_t     push_data,
  input  logic               pop,
  output spcd_pkg::job_t     pop_data,
  output spcd_pkg::q_stat_t  stat
);

  spcd_pkg::job_t           mem_r [spcd_pkg::QDEPTH];
  logic [spcd_pkg::QAW-1:0] wr_r, rd_r;
  logic [spcd_pkg::QAW:0]   cnt_r;

  always_ff @(posedge clk) begin
    if (push) mem_r[wr_r] <= push_data;
  end

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= '0;
      rd_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (push) wr_r <= wr_r + 1'b1;
      if (pop)  rd_r <= rd_r + 1'b1;
      if (push && !pop)      cnt_r <= cnt_r + 1'b1;
      else if (pop && !push) cnt_r <= cnt_r - 1'b1;
    end
  end

  assign pop_data   = mem_r[rd_r];
  assign stat.full  = cnt_r == (spcd_pkg::QAW + 1)'(spcd_pkg::QDEPTH);
  assign stat.empty = cnt_r == '0;

endmodule

// ===== hw/rtl/spcd_back.sv =====
// Back: two pipelined Q0.16 dividers, then the squared distance.
module spcd_back (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     src_valid,
  input  spcd_pkg::job_t           src_job,
  output logic                     pop,
  input  logic [spcd_pkg::LW-1:0]  lim,
  output logic                     out_valid,
  input  logic                     out_ready,
  output spcd_pkg::dist_t          out_dist,
  output spcd_pkg::frac_t          out_frac_a,
  output spcd_pkg::frac_t          out_frac_b
);

  localparam int NS = spcd_pkg::DIV_STEPS;

  typedef struct packed {
    logic s_one;
    logic s_zero;
    logic t_one;
    logic t_zero;
  } pick_t;

  logic                   en;
  logic [21:0]            vb_r;
  logic                   out_valid_r;
  spcd_pkg::wide_t        lim_w;
  spcd_pkg::geom_t        gb_r [0:17];
  pick_t                  pk_r [0:NS];
  pick_t                  pk_n;
  logic [spcd_pkg::WW-1:0] sr_r [0:NS], tr_r [0:NS], sdn_r [0:NS], tdn_r [0:NS];
  logic [spcd_pkg::WW-1:0] sr_n [1:NS], tr_n [1:NS];
  logic [NS-1:0]          sq_r [0:NS], tq_r [0:NS];
  logic [NS-1:0]          sq_n [1:NS], tq_n [1:NS];
  spcd_pkg::frac_t        fs_r [17:22], ft_r [17:22];
  spcd_pkg::frac_t        fs_n, ft_n;
  spcd_pkg::mp_t          mu_r [3], mv_r [3], ws_r [3];
  spcd_pkg::mop_t         p_r [3];
  spcd_pkg::wide_t        sq [3];
  spcd_pkg::wide_t        acc;
  spcd_pkg::dist_t        dist_n, dist_r;

  // one restoring step: {quotient bit, remainder}
  function automatic logic [spcd_pkg::WW:0] div_step(
    input logic [spcd_pkg::WW-1:0] r,
    input logic [spcd_pkg::WW-1:0] dn
  );
    logic [spcd_pkg::WW:0] rs, d1;
    logic                  ge;
    rs = {r, 1'b0};
    d1 = {1'b0, dn};
    ge = rs >= d1;
    div_step = ge ? {1'b1, spcd_pkg::WW'(rs - d1)} : {1'b0, rs[spcd_pkg::WW-1:0]};
  endfunction

  assign en    = !out_valid_r || out_ready;
  assign pop   = en && src_valid;
  assign lim_w = spcd_pkg::wide_t'({1'b0, lim});

  // zero / full-scale decisions ahead of the divide
  always_comb begin
    logic s_zero, s_ge, t_zero, t_ge;
    s_zero = (src_job.sn < lim_w) || (src_job.sd <= 0);
    s_ge   = src_job.sn >= src_job.sd;
    t_zero = (src_job.tn < lim_w) || (src_job.td <= 0);
    t_ge   = src_job.tn >= src_job.td;
    pk_n.s_one  = src_job.s_one || (!s_zero && s_ge);
    pk_n.s_zero = !src_job.s_one && s_zero;
    pk_n.t_one  = !t_zero && t_ge;
    pk_n.t_zero = t_zero;
  end

  // divider steps
  always_comb begin
    logic [spcd_pkg::WW:0] rs, rt;
    for (int i = 1; i <= NS; i++) begin
      rs = div_step(sr_r[i - 1], sdn_r[i - 1]);
      rt = div_step(tr_r[i - 1], tdn_r[i - 1]);
      sr_n[i] = rs[spcd_pkg::WW-1:0];
      tr_n[i] = rt[spcd_pkg::WW-1:0];
      sq_n[i] = {sq_r[i - 1][NS-2:0], rs[spcd_pkg::WW]};
      tq_n[i] = {tq_r[i - 1][NS-2:0], rt[spcd_pkg::WW]};
    end
  end

  // final parameters
  always_comb begin
    if (pk_r[NS].s_one)       fs_n = spcd_pkg::ONE_Q16;
    else if (pk_r[NS].s_zero) fs_n = '0;
    else                      fs_n = {1'b0, sq_r[NS]};
    if (pk_r[NS].t_zero)      ft_n = '0;
    else if (pk_r[NS].t_one)  ft_n = spcd_pkg::ONE_Q16;
    else                      ft_n = {1'b0, tq_r[NS]};
  end

  // squared components
  spcd_wmul u_sq0 (.clk, .en, .x(p_r[0]), .y(p_r[0]), .p(sq[0]));
  spcd_wmul u_sq1 (.clk, .en, .x(p_r[1]), .y(p_r[1]), .p(sq[1]));
  spcd_wmul u_sq2 (.clk, .en, .x(p_r[2]), .y(p_r[2]), .p(sq[2]));

  // sum, scale to Q.16, saturate
  always_comb begin
    acc    = sq[0] + sq[1] + sq[2];
    dist_n = (|acc[spcd_pkg::WW-1:spcd_pkg::SAT_BIT]) ? '1
           : acc[spcd_pkg::SAT_BIT-1:spcd_pkg::DIST_SHIFT];
  end

  // stage valids
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vb_r        <= '0;
      out_valid_r <= 1'b0;
    end else if (en) begin
      vb_r        <= {vb_r[20:0], pop};
      out_valid_r <= vb_r[21];
    end
  end

  // stage payloads
  always_ff @(posedge clk) begin
    if (en) begin
      gb_r[0]  <= src_job.g;
      pk_r[0]  <= pk_n;
      sr_r[0]  <= src_job.sn[spcd_pkg::WW-1:0];
      tr_r[0]  <= src_job.tn[spcd_pkg::WW-1:0];
      sdn_r[0] <= src_job.sd[spcd_pkg::WW-1:0];
      tdn_r[0] <= src_job.td[spcd_pkg::WW-1:0];
      sq_r[0]  <= '0;
      tq_r[0]  <= '0;
      for (int i = 1; i <= NS; i++) begin
        sr_r[i]  <= sr_n[i];
        tr_r[i]  <= tr_n[i];
        sq_r[i]  <= sq_n[i];
        tq_r[i]  <= tq_n[i];
        sdn_r[i] <= sdn_r[i - 1];
        tdn_r[i] <= tdn_r[i - 1];
        pk_r[i]  <= pk_r[i - 1];
      end
      for (int i = 1; i <= 17; i++) begin
        gb_r[i] <= gb_r[i - 1];
      end
      fs_r[17] <= fs_n;
      ft_r[17] <= ft_n;
      for (int i = 18; i <= 22; i++) begin
        fs_r[i] <= fs_r[i - 1];
        ft_r[i] <= ft_r[i - 1];
      end
      for (int k = 0; k < 3; k++) begin
        mu_r[k] <= spcd_pkg::mp_t'($signed(gb_r[17].u[k]))
                 * spcd_pkg::mp_t'($signed({1'b0, fs_r[17]}));
        mv_r[k] <= spcd_pkg::mp_t'($signed(gb_r[17].v[k]))
                 * spcd_pkg::mp_t'($signed({1'b0, ft_r[17]}));
        ws_r[k] <= spcd_pkg::mp_t'($signed(gb_r[17].w[k])) <<< spcd_pkg::FRAC_BITS;
        p_r[k]  <= spcd_pkg::mop_t'(ws_r[k]) + spcd_pkg::mop_t'(mu_r[k])
                 - spcd_pkg::mop_t'(mv_r[k]);
      end
      dist_r <= dist_n;
    end
  end

  // final-stage registers double as the output register
  assign out_valid  = out_valid_r;
  assign out_dist   = dist_r;
  assign out_frac_a = fs_r[22];
  assign out_frac_b = ft_r[22];

endmodule

// ===== hw/rtl/segment_pair_closest_distance_core.sv =====
// Closest distance between two 3D segments. One segment pair is taken per clock while the queue
// is not full, and one result leaves per clock while out_tready is high. A pair passes through
// the classifying front, then the four-entry queue, then the back.
// The back length is set by the two 16-stage restoring dividers that form the Q1.16 parameters;
// the front length by the split wide multipliers. The queue lets the front keep taking pairs
// while the result side is stalled, until the queue fills. cfg_data sets the near-zero limit
// (reset 1); write it only while no pair is in flight.
module segment_pair_closest_distance_core (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_tvalid,
  output logic                         in_tready,
  // a_start_x/y/z, a_axis_x/y/z, b_start_x/y/z, b_axis_x/y/z, 24 bits each, lowest first
  input  logic [spcd_pkg::IN_W-1:0]    in_tdata,
  output logic                         out_tvalid,
  input  logic                         out_tready,
  // distance_squared [53:0], frac_a [70:54], frac_b [87:71]
  output logic [spcd_pkg::OUT_W-1:0]   out_tdata,
  input  logic                         cfg_valid,
  output logic                         cfg_ready,
  input  logic [spcd_pkg::LW-1:0]      cfg_data
);

  logic [spcd_pkg::LW-1:0] lim_r;
  logic                    front_en;
  logic                    fr_valid;
  spcd_pkg::job_t          fr_job, q_job;
  spcd_pkg::q_stat_t       q_stat;
  logic                    q_push, q_pop;
  spcd_pkg::dist_t         dist_sq;
  spcd_pkg::frac_t         frac_a, frac_b;

  // limit register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lim_r <= spcd_pkg::LIMIT_RESET;
    end else if (cfg_valid) begin
      lim_r <= cfg_data;
    end
  end
  assign cfg_ready = 1'b1;

  assign front_en  = !q_stat.full;
  assign in_tready = front_en;
  assign q_push    = front_en && fr_valid;

  spcd_front u_front (
    .clk,
    .rst_n,
    .en        (front_en),
    .in_valid  (in_tvalid),
    .in_data   (in_tdata),
    .lim       (lim_r),
    .out_valid (fr_valid),
    .out_job   (fr_job)
  );

  spcd_queue u_queue (
    .clk,
    .rst_n,
    .push      (q_push),
    .push_data (fr_job),
    .pop       (q_pop),
    .pop_data  (q_job),
    .stat      (q_stat)
  );

  spcd_back u_back (
    .clk,
    .rst_n,
    .src_valid  (!q_stat.empty),
    .src_job    (q_job),
    .pop        (q_pop),
    .lim        (lim_r),
    .out_valid  (out_tvalid),
    .out_ready  (out_tready),
    .out_dist   (dist_sq),
    .out_frac_a (frac_a),
    .out_frac_b (frac_b)
  );

  assign out_tdata = {frac_b, frac_a, dist_sq};

`ifndef SYNTHESIS
  a_frac_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (frac_a <= spcd_pkg::ONE_Q16) && (frac_b <= spcd_pkg::ONE_Q16))
    else $error("parameter above one");
  a_queue_state: assert property (@(posedge clk) disable iff (!rst_n)
    !(q_stat.full && q_stat.empty))
    else $error("queue full and empty at once");
  a_no_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> !q_stat.empty)
    else $error("pop from empty queue");
`endif

endmodule
